FILE: rtl/core/nbbe_pkg.sv
// Shared types and constants for the nonzero bounding box block.
// Used by nbbe_track and the top level; no dependencies.
package nbbe_pkg;

  // Configuration register width and register indexes
  localparam int CFG_W = 12;
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Output field widths
  localparam int BOX_W = 12;
  localparam int PT_W  = 11;

  // Effective frame geometry after clamping, plus last column and row index
  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic [CFG_W-1:0] last_col;
    logic [CFG_W-1:0] last_row;
  } frame_geom_t;

  // One frame result
  typedef struct packed {
    logic [BOX_W-1:0] box_x;
    logic [BOX_W-1:0] box_y;
    logic [BOX_W-1:0] box_width;
    logic [BOX_W-1:0] box_height;
    logic [PT_W-1:0]  top_x;
    logic [PT_W-1:0]  top_y;
    logic [PT_W-1:0]  left_x;
    logic [PT_W-1:0]  left_y;
    logic [PT_W-1:0]  bottom_x;
    logic [PT_W-1:0]  bottom_y;
    logic [PT_W-1:0]  right_x;
    logic [PT_W-1:0]  right_y;
  } box_result_t;

endpackage

FILE: rtl/core/nonzero_bounding_box_extremes.sv
// Bounding box and extreme points of the nonzero pixels in a raster frame.
// The result is registered: it loads as the frame's last pixel leaves the input register.
// Throughput: one pixel per clock, set by the input register feeding the tracker;
// only the last pixel of a frame waits while an earlier result is still held.
// Reset: frame size returns to 400 by 400 (clamped to MAX_SIDE), position to
// the first pixel, and both channels empty. Depends on nbbe_pkg, nbbe_track.
module nonzero_bounding_box_extremes import nbbe_pkg::*; #(
  parameter int MAX_SIDE = 2048
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_write,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  // pixel stream
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  logic [7:0]        pixel,
  // frame result
  output logic              box_valid,
  input  logic              box_stall,
  output logic [BOX_W-1:0]  box_x,
  output logic [BOX_W-1:0]  box_y,
  output logic [BOX_W-1:0]  box_width,
  output logic [BOX_W-1:0]  box_height,
  output logic [PT_W-1:0]   top_point_x,
  output logic [PT_W-1:0]   top_point_y,
  output logic [PT_W-1:0]   left_point_x,
  output logic [PT_W-1:0]   left_point_y,
  output logic [PT_W-1:0]   bottom_point_x,
  output logic [PT_W-1:0]   bottom_point_y,
  output logic [PT_W-1:0]   right_point_x,
  output logic [PT_W-1:0]   right_point_y
);

  localparam int EFF_MAX   = (MAX_SIDE < 4095) ? MAX_SIDE : 4095;
  localparam int RESET_EFF = (400 > EFF_MAX) ? EFF_MAX : 400;
  localparam logic [CFG_W-1:0] SIDE_CAP   = CFG_W'(EFF_MAX);
  localparam logic [CFG_W-1:0] RESET_SIDE = CFG_W'(RESET_EFF);

  frame_geom_t      geom;
  logic [CFG_W-1:0] side_eff;
  logic             restart;

  logic             s1_valid;
  logic [7:0]       s1_pixel;
  logic             s1_go;
  logic             frame_end;
  logic             out_free;
  box_result_t      track_result;
  box_result_t      box_reg;

  // Clamp the written size into 1..MAX_SIDE, and to at most 4095
  always_comb begin
    if (cfg_data == '0) begin
      side_eff = CFG_W'(1);
    end else if (32'(cfg_data) > MAX_SIDE) begin
      side_eff = SIDE_CAP;
    end else begin
      side_eff = cfg_data;
    end
  end

  assign restart = cfg_write &&
                   (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  // Hold the effective frame geometry
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.width    <= RESET_SIDE;
      geom.height   <= RESET_SIDE;
      geom.last_col <= RESET_SIDE - CFG_W'(1);
      geom.last_row <= RESET_SIDE - CFG_W'(1);
    end else if (cfg_write) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        geom.width    <= side_eff;
        geom.last_col <= side_eff - CFG_W'(1);
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        geom.height   <= side_eff;
        geom.last_row <= side_eff - CFG_W'(1);
      end
    end
  end

  // Handshake: the last pixel of a frame needs a free result register
  assign out_free    = !box_valid || !box_stall;
  assign s1_go       = s1_valid && (!frame_end || out_free);
  assign pixel_stall = s1_valid && !s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_valid && !pixel_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && !pixel_stall) begin
      s1_pixel <= pixel;
    end
  end

  nbbe_track #(
    .MAX_SIDE (MAX_SIDE)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .step      (s1_go),
    .pixel     (s1_pixel),
    .geom      (geom),
    .frame_end (frame_end),
    .result    (track_result)
  );

  // Result register: load on frame end, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (s1_go && frame_end) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && frame_end) begin
      box_reg <= track_result;
    end
  end

  assign box_x          = box_reg.box_x;
  assign box_y          = box_reg.box_y;
  assign box_width      = box_reg.box_width;
  assign box_height     = box_reg.box_height;
  assign top_point_x    = box_reg.top_x;
  assign top_point_y    = box_reg.top_y;
  assign left_point_x   = box_reg.left_x;
  assign left_point_y   = box_reg.left_y;
  assign bottom_point_x = box_reg.bottom_x;
  assign bottom_point_y = box_reg.bottom_y;
  assign right_point_x  = box_reg.right_x;
  assign right_point_y  = box_reg.right_y;

  // Stall only while a pixel sits in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> s1_valid)
    else $error("pixel stall raised with empty input register");

  // An empty frame has zero width and zero height together
  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    (box_valid && box_width == '0) |-> (box_height == '0))
    else $error("empty result with nonzero height");

  // A nonempty box lies inside the frame width
  a_box_inside: assert property (@(posedge clk) disable iff (rst)
    (box_valid && box_width != '0) |->
      ({1'b0, box_x} + {1'b0, box_width} <= {1'b0, geom.width}))
    else $error("bounding box extends past frame width");

endmodule

FILE: rtl/core/nbbe_track.sv
// Raster position counters and extreme point tracking for one frame.
// Builds the frame result from the updated points. Depends on nbbe_pkg.
module nbbe_track import nbbe_pkg::*; #(
  parameter int MAX_SIDE = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        restart,
  input  logic        step,
  input  logic [7:0]  pixel,
  input  frame_geom_t geom,
  output logic        frame_end,
  output box_result_t result
);

  localparam int EFF_MAX = (MAX_SIDE < 4095) ? MAX_SIDE : 4095;
  localparam int PW      = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;

  typedef struct packed {
    logic [PW-1:0] x;
    logic [PW-1:0] y;
  } point_t;

  logic [PW-1:0] col;
  logic [PW-1:0] row;
  logic          seen;
  point_t        top_pt, left_pt, bottom_pt, right_pt;

  logic          seen_next;
  point_t        top_next, left_next, bottom_next, right_next;
  point_t        here;
  logic [PW:0]   span_x, span_y;

  // Fold the current pixel into the extreme points
  always_comb begin
    here        = '{x: col, y: row};
    seen_next   = seen;
    top_next    = top_pt;
    left_next   = left_pt;
    bottom_next = bottom_pt;
    right_next  = right_pt;
    if (pixel != 8'd0) begin
      if (!seen) begin
        seen_next   = 1'b1;
        top_next    = here;
        left_next   = here;
        bottom_next = here;
        right_next  = here;
      end else begin
        if (col < left_pt.x)   left_next   = here;
        if (row > bottom_pt.y) bottom_next = here;
        if (col > right_pt.x)  right_next  = here;
      end
    end
  end

  assign frame_end = (col >= PW'(geom.last_col)) && (row >= PW'(geom.last_row));

  // Build the crop rectangle and points, or the empty-frame result
  always_comb begin
    span_x = {1'b0, right_next.x} - {1'b0, left_next.x} + (PW+1)'(1);
    span_y = {1'b0, bottom_next.y} - {1'b0, top_next.y} + (PW+1)'(1);
    result = '0;
    if (seen_next) begin
      result.box_x      = BOX_W'(left_next.x);
      result.box_y      = BOX_W'(top_next.y);
      result.box_width  = BOX_W'(span_x);
      result.box_height = BOX_W'(span_y);
      result.top_x      = PT_W'(top_next.x);
      result.top_y      = PT_W'(top_next.y);
      result.left_x     = PT_W'(left_next.x);
      result.left_y     = PT_W'(left_next.y);
      result.bottom_x   = PT_W'(bottom_next.x);
      result.bottom_y   = PT_W'(bottom_next.y);
      result.right_x    = PT_W'(right_next.x);
      result.right_y    = PT_W'(right_next.y);
    end else begin
      result.box_x = geom.width;
      result.box_y = geom.height;
    end
  end

  // Advance the raster position; restart on frame end or geometry register write
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col  <= '0;
      row  <= '0;
      seen <= 1'b0;
    end else if (step) begin
      if (frame_end) begin
        col  <= '0;
        row  <= '0;
        seen <= 1'b0;
      end else begin
        seen <= seen_next;
        if (col >= PW'(geom.last_col)) begin
          col <= '0;
          row <= row + PW'(1);
        end else begin
          col <= col + PW'(1);
        end
      end
    end
  end

  // Hold the points; they are only read while seen is set
  always_ff @(posedge clk) begin
    if (step) begin
      top_pt    <= top_next;
      left_pt   <= left_next;
      bottom_pt <= bottom_next;
      right_pt  <= right_next;
    end
  end

endmodule

FILE: test/nbbe_box_checker.sv
// Checker for the nonzero bounding box block: watches the config port and both
// channels, predicts each frame result and compares it field by field.
// Depends on nbbe_pkg for widths, register indexes and the result struct.
module nbbe_box_checker import nbbe_pkg::*; #(
  parameter int MAX_SIDE = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              pixel_valid,
  input  logic              pixel_stall,
  input  logic [7:0]        pixel,
  input  logic              box_valid,
  input  logic              box_stall,
  input  logic [BOX_W-1:0]  box_x,
  input  logic [BOX_W-1:0]  box_y,
  input  logic [BOX_W-1:0]  box_width,
  input  logic [BOX_W-1:0]  box_height,
  input  logic [PT_W-1:0]   top_point_x,
  input  logic [PT_W-1:0]   top_point_y,
  input  logic [PT_W-1:0]   left_point_x,
  input  logic [PT_W-1:0]   left_point_y,
  input  logic [PT_W-1:0]   bottom_point_x,
  input  logic [PT_W-1:0]   bottom_point_y,
  input  logic [PT_W-1:0]   right_point_x,
  input  logic [PT_W-1:0]   right_point_y,
  output int                mismatches,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
  } spot_t;

  // Shadow of the block: geometry registers, raster position, extremes so far
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      col_pos;
  int unsigned      row_pos;
  bit               content_seen;
  spot_t            top_spot;
  spot_t            left_spot;
  spot_t            bottom_spot;
  spot_t            right_spot;

  box_result_t expected_boxes[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic int unsigned clamp_side(input logic [CFG_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_SIDE) return MAX_SIDE;
    return raw;
  endfunction

  task automatic restart_frame();
    col_pos = 0;
    row_pos = 0;
    content_seen = 1'b0;
    top_spot = '0;
    left_spot = '0;
    bottom_spot = '0;
    right_spot = '0;
  endtask

  // Advance the raster by one pixel; queue a result on the frame's last pixel
  task automatic predict_pixel(input logic [7:0] value);
    int unsigned w;
    int unsigned h;
    spot_t       here;
    box_result_t res;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    here.x = PT_W'(col_pos);
    here.y = PT_W'(row_pos);
    if (value != 8'd0) begin
      if (!content_seen) begin
        content_seen = 1'b1;
        top_spot = here;
        left_spot = here;
        bottom_spot = here;
        right_spot = here;
      end else begin
        if (here.x < left_spot.x) left_spot = here;
        if (here.y > bottom_spot.y) bottom_spot = here;
        if (here.x > right_spot.x) right_spot = here;
      end
    end
    if (col_pos + 1 >= w && row_pos + 1 >= h) begin
      res = '0;
      if (content_seen) begin
        res.box_x = BOX_W'(left_spot.x);
        res.box_y = BOX_W'(top_spot.y);
        res.box_width = BOX_W'(int'(right_spot.x) - int'(left_spot.x) + 1);
        res.box_height = BOX_W'(int'(bottom_spot.y) - int'(top_spot.y) + 1);
        res.top_x = top_spot.x;
        res.top_y = top_spot.y;
        res.left_x = left_spot.x;
        res.left_y = left_spot.y;
        res.bottom_x = bottom_spot.x;
        res.bottom_y = bottom_spot.y;
        res.right_x = right_spot.x;
        res.right_y = right_spot.y;
      end else begin
        // empty frame reports the frame size as origin and a zero span
        res.box_x = BOX_W'(w);
        res.box_y = BOX_W'(h);
      end
      expected_boxes.insert(expected_boxes.size(), res);
      restart_frame();
    end else if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic check_field(input string name, input logic [BOX_W-1:0] want,
                             input logic [BOX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare one result transaction with the oldest expected frame
  task automatic check_box();
    box_result_t want;
    if (expected_boxes.size() == 0) begin
      $error("box result transaction with no frame outstanding");
      mismatches++;
      return;
    end
    want = expected_boxes.pop_front();
    check_field("box_x", want.box_x, box_x);
    check_field("box_y", want.box_y, box_y);
    check_field("box_width", want.box_width, box_width);
    check_field("box_height", want.box_height, box_height);
    check_field("top_point_x", want.top_x, top_point_x);
    check_field("top_point_y", want.top_y, top_point_y);
    check_field("left_point_x", want.left_x, left_point_x);
    check_field("left_point_y", want.left_y, left_point_y);
    check_field("bottom_point_x", want.bottom_x, bottom_point_x);
    check_field("bottom_point_y", want.bottom_y, bottom_point_y);
    check_field("right_point_x", want.right_x, right_point_x);
    check_field("right_point_y", want.right_y, right_point_y);
  endtask

  // Sample both channels and the config port at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      width_reg = CFG_W'(400);
      height_reg = CFG_W'(400);
      restart_frame();
      expected_boxes.delete();
    end else begin
      if (box_valid && !box_stall) check_box();
      if (cfg_write) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_data;
          restart_frame();
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_reg = cfg_data;
          restart_frame();
        end
      end
      if (pixel_valid && !pixel_stall) predict_pixel(pixel);
    end
    pending = expected_boxes.size();
  end

endmodule

FILE: test/tb_nonzero_bounding_box_extremes.sv
// Top of the bounding box testbench: clock, reset, frame stimulus and verdict.
// Depends on nbbe_pkg, nonzero_bounding_box_extremes and nbbe_box_checker.
module tb_nonzero_bounding_box_extremes import nbbe_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SIDE = 2048;
  localparam longint LIMIT_NS = 64'd20_000_000;

  // Indexes past the two geometry registers; writes there change nothing
  localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {
    FRAME_EMPTY,
    FRAME_SPARSE,
    FRAME_DENSE,
    FRAME_DOT,
    FRAME_ROW,
    FRAME_COL
  } frame_kind_e;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              pixel_valid = 1'b0;
  logic              pixel_stall;
  logic [7:0]        pixel = 8'd0;
  logic              box_valid;
  logic              box_stall = 1'b0;
  logic [BOX_W-1:0]  box_x, box_y, box_width, box_height;
  logic [PT_W-1:0]   top_point_x, top_point_y, left_point_x, left_point_y;
  logic [PT_W-1:0]   bottom_point_x, bottom_point_y, right_point_x, right_point_y;

  int mismatches;
  int pending;
  int sender_idle = 35;
  int receiver_idle = 79;
  int cur_w = 400;
  int cur_h = 400;
  int pixels_sent = 0;
  int frames_sent = 0;
  int reg_writes = 0;

  nonzero_bounding_box_extremes #(.MAX_SIDE(MAX_SIDE)) u_top (.*);

  nbbe_box_checker #(.MAX_SIDE(MAX_SIDE)) u_checker (.*);

  always #10 clk = ~clk;

  // Receiver backpressure, re-drawn every cycle
  always @(posedge clk) box_stall <= ($urandom_range(99) < receiver_idle);

  function automatic int side_of(input logic [CFG_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_SIDE) return MAX_SIDE;
    return raw;
  endfunction

  function automatic logic [CFG_W-1:0] pick_side(input int cap);
    if ($urandom_range(15) == 0) return CFG_W'($urandom_range(12, 9));
    return CFG_W'($urandom_range(cap, 0));
  endfunction

  // Offer one pixel, idling first at random, and hold it until taken
  task automatic push_pixel(input logic [7:0] value);
    while ($urandom_range(99) < sender_idle) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= value;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Drop valid and wait until every expected frame has come out
  task automatic settle();
    pixel_valid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (index == REG_FRAME_WIDTH) cur_w = side_of(value);
    else if (index == REG_FRAME_HEIGHT) cur_h = side_of(value);
    reg_writes++;
  endtask

  // Send the first count pixels of a frame with content shaped by kind
  task automatic send_frame(input frame_kind_e kind, input bit mark_last, input int count);
    int         total;
    int         spot_row;
    int         spot_col;
    int         r;
    int         c;
    bit         lit;
    logic [7:0] value;
    total = cur_w * cur_h;
    spot_row = $urandom_range(cur_h - 1);
    spot_col = $urandom_range(cur_w - 1);
    for (int k = 0; k < count; k++) begin
      r = k / cur_w;
      c = k % cur_w;
      case (kind)
        FRAME_EMPTY:  lit = 1'b0;
        FRAME_SPARSE: lit = ($urandom_range(7) == 0);
        FRAME_DENSE:  lit = ($urandom_range(3) != 0);
        FRAME_DOT:    lit = (r == spot_row && c == spot_col);
        FRAME_ROW:    lit = (r == spot_row) && ($urandom_range(1) == 1);
        default:      lit = (c == spot_col) && ($urandom_range(1) == 1);
      endcase
      if (mark_last && k == total - 1) lit = 1'b1;
      value = lit ? 8'($urandom_range(255, 1)) : 8'd0;
      push_pixel(value);
    end
    if (count == total) frames_sent++;
  endtask

  // One geometry setting, a few whole frames, sometimes a cut-off frame
  task automatic random_session();
    int frames;
    int total;
    settle();
    case ($urandom_range(3))
      0: write_reg(REG_FRAME_WIDTH, pick_side(6));
      1: write_reg(REG_FRAME_HEIGHT, pick_side(5));
      default: begin
        write_reg(REG_FRAME_WIDTH, pick_side(6));
        write_reg(REG_FRAME_HEIGHT, pick_side(5));
      end
    endcase
    if ($urandom_range(9) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom_range(4095)));
    end
    total = cur_w * cur_h;
    frames = $urandom_range(3, 1);
    repeat (frames) send_frame(frame_kind_e'($urandom_range(5)), 1'b0, total);
    if (total > 1 && $urandom_range(5) == 0) begin
      send_frame(frame_kind_e'($urandom_range(5)), 1'b0, $urandom_range(total - 1, 1));
    end
  endtask

  initial begin
    logic [7:0] diamond [9] = '{8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd128, 8'd0, 8'd7, 8'd0};
    int         pix_mark;
    int         frame_mark;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Height only: the width still holds its reset value of 400
    write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
    send_frame(FRAME_SPARSE, 1'b1, cur_w * cur_h);

    // Four distinct extreme points in a 3x3 frame
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(3));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
    foreach (diamond[i]) push_pixel(diamond[i]);
    frames_sent++;

    // Zero sizes clamp to 1: a single lit pixel, then an empty frame
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(0));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(0));
    push_pixel(8'd255);
    push_pixel(8'd0);
    frames_sent += 2;

    // A write to an unused index mid-frame must not restart the frame
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(4));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
    push_pixel(8'd0);
    push_pixel(8'h80);
    push_pixel(8'h55);
    settle();
    write_reg(REG_SPARE_B, CFG_W'(4095));
    push_pixel(8'h2a);
    push_pixel(8'd0);
    push_pixel(8'd0);
    push_pixel(8'h01);
    push_pixel(8'd0);
    frames_sent++;

    // A geometry write mid-frame discards the partial frame
    push_pixel(8'hff);
    push_pixel(8'hff);
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(4));
    send_frame(FRAME_DENSE, 1'b0, cur_w * cur_h);

    // Random frames under three idling mixes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle = 35;
          receiver_idle = 79;
        end
        1: begin
          sender_idle = 79;
          receiver_idle = 35;
        end
        default: begin
          sender_idle = 0;
          receiver_idle = 0;
        end
      endcase
      pix_mark = pixels_sent;
      frame_mark = frames_sent;
      while (pixels_sent - pix_mark < 110 || frames_sent - frame_mark < 8) begin
        random_session();
      end
    end

    settle();
    $display("Run covered %0d pixels in %0d complete frames with %0d register writes,",
             pixels_sent, frames_sent, reg_writes);
    $display("from 1x1 frames up to 400-pixel rows, under three backpressure mixes.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #(LIMIT_NS);
    $display("Timeout: run did not complete");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/nbbe_pkg.sv
rtl/core/nbbe_track.sv
rtl/core/nonzero_bounding_box_extremes.sv
test/nbbe_box_checker.sv
test/tb_nonzero_bounding_box_extremes.sv
